>>> rtl/psched_pkg.sv
// ----------------------------------------------------------------------------
// psched_pkg
// Shared constants and types for the process scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

    localparam int MAX_PROCS = 64;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int FIELD_W   = 16;
    localparam int CLOCK_W   = 24;
    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_PRIO = 2'd1;
    localparam logic [1:0] MODE_SJF  = 2'd2;
    localparam logic [1:0] MODE_RR   = 2'd3;

    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] pid;
        logic [FIELD_W-1:0] burst;
        logic [FIELD_W-1:0] prio;
        logic [FIELD_W-1:0] arrival;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               vld;
        logic [FIELD_W-1:0] key;
        logic [IDX_W-1:0]   idx;
        logic [FIELD_W-1:0] pid;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] rem;
    } t_cand;

endpackage

>>> rtl/psched_ram.sv
// ----------------------------------------------------------------------------
// psched_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psched_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/process_scheduler_fcfs_sjf_prio_rr.sv
// ----------------------------------------------------------------------------
// process_scheduler_fcfs_sjf_prio_rr
// Process table scheduler: FCFS, priority, shortest job and round robin.
// Load and clear transactions take effect as they are accepted. A step scans the
// table through the shared RAM read address, one entry per cycle, after reading
// the last entry's arrival in round robin (S_LA, S_LAW); the result is registered
// when the output is free, and no new transaction is accepted before that.
// Synchronous active-low reset empties the table, sets mode 0 and quantum 1.
// ----------------------------------------------------------------------------
module process_scheduler_fcfs_sjf_prio_rr (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_proc_id,
    input  logic [15:0] i_burst_len,
    input  logic [15:0] i_prio_level,
    input  logic [15:0] i_arrive_at,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_slice_pid,
    output logic [23:0] o_slice_start,
    output logic [23:0] o_slice_end,
    output logic        o_proc_finished,
    output logic        o_all_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LA   = 2'd1;
    localparam logic [1:0] S_LAW  = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    localparam int IW = psched_pkg::IDX_W;
    localparam int CW = psched_pkg::CNT_W;
    localparam int FW = psched_pkg::FIELD_W;
    localparam int KW = psched_pkg::CLOCK_W;

    logic [1:0]             r_state, n_state;
    logic                   r_fin, n_fin;
    logic [1:0]             r_mode, n_mode;
    logic [FW-1:0]          r_quantum, n_quantum;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_undone, n_undone;
    logic [KW-1:0]          r_clock, n_clock;
    logic [IW-1:0]          r_last, n_last;
    logic                   r_rr_started, n_rr_started;
    logic [psched_pkg::MAX_PROCS-1:0] r_done, n_done;
    logic [CW-1:0]          r_iss, n_iss;
    logic                   r_dv, n_dv;
    logic                   r_out_valid, n_out_valid;

    logic [IW-1:0]          r_didx, n_didx;
    logic [FW-1:0]          r_la, n_la;
    psched_pkg::t_cand      r_min, n_min, r_aft, n_aft, sel;
    logic [FW-1:0]          r_pid, n_pid;
    logic [KW-1:0]          r_start, n_start, r_end, n_end;
    logic                   r_pfin, n_pfin, r_all, n_all;

    logic                   st_we, rm_we;
    logic [IW-1:0]          st_waddr, rm_waddr, rd_addr;
    psched_pkg::t_entry     st_wdata, st_rdata;
    logic [FW-1:0]          rm_wdata, rm_rdata;

    logic                   in_fire, rr, use_aft, after_ok, fin_now;
    logic [FW-1:0]          key, q, run, rem_new;
    logic [KW-1:0]          start, arr_ext;
    logic [KW:0]            sum;

    psched_ram #(.WIDTH(psched_pkg::ENTRY_W), .DEPTH(psched_pkg::MAX_PROCS)) u_static_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (rd_addr),
        .o_rdata (st_rdata)
    );

    psched_ram #(.WIDTH(FW), .DEPTH(psched_pkg::MAX_PROCS)) u_remain_ram (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_waddr),
        .i_wdata (rm_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rm_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE) && !r_fin;
    assign in_fire    = i_in_valid && o_in_ready;
    assign rr         = (r_mode == psched_pkg::MODE_RR);
    assign rd_addr    = (r_state == S_LA) ? r_last : r_iss[IW-1:0];

    always_comb begin
        case (r_mode)
            psched_pkg::MODE_PRIO: key = st_rdata.prio;
            psched_pkg::MODE_SJF:  key = st_rdata.burst;
            default:               key = st_rdata.arrival;
        endcase
    end

    assign after_ok = (r_la < st_rdata.arrival) ||
                      ((r_la == st_rdata.arrival) && (r_last < r_didx));

    assign use_aft  = rr && r_rr_started && ({1'b0, r_last} < r_count) && r_aft.vld;
    assign sel      = use_aft ? r_aft : r_min;
    assign arr_ext  = {{(KW-FW){1'b0}}, sel.arr};
    assign start    = (r_clock > arr_ext) ? r_clock : arr_ext;
    assign q        = (r_quantum == '0) ? FW'(1) : r_quantum;
    assign run      = (rr && (sel.rem > q)) ? q : sel.rem;
    assign sum      = {1'b0, start} + (KW+1)'(run);
    assign rem_new  = sel.rem - run;
    assign fin_now  = (rem_new == '0);

    always_comb begin
        n_state      = r_state;
        n_fin        = r_fin;
        n_mode       = r_mode;
        n_quantum    = r_quantum;
        n_count      = r_count;
        n_undone     = r_undone;
        n_clock      = r_clock;
        n_last       = r_last;
        n_rr_started = r_rr_started;
        n_done       = r_done;
        n_iss        = r_iss;
        n_dv         = 1'b0;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_didx       = r_didx;
        n_la         = r_la;
        n_min        = r_min;
        n_aft        = r_aft;
        n_pid        = r_pid;
        n_start      = r_start;
        n_end        = r_end;
        n_pfin       = r_pfin;
        n_all        = r_all;
        st_we        = 1'b0;
        st_waddr     = r_count[IW-1:0];
        st_wdata     = '{pid: i_proc_id, burst: i_burst_len,
                         prio: i_prio_level, arrival: i_arrive_at};
        rm_we        = 1'b0;
        rm_waddr     = r_count[IW-1:0];
        rm_wdata     = i_burst_len;

        if (i_cfg_we) begin
            case (i_cfg_index)
                psched_pkg::CFG_MODE:    n_mode    = i_cfg_data[1:0];
                psched_pkg::CFG_QUANTUM: n_quantum = i_cfg_data;
                default: ;
            endcase
        end

        if (r_fin) begin
            if (!r_out_valid || i_out_ready) begin
                rm_we        = 1'b1;
                rm_waddr     = sel.idx;
                rm_wdata     = rem_new;
                n_done[sel.idx] = fin_now;
                n_undone     = r_undone - CW'(fin_now);
                n_clock      = sum[KW] ? psched_pkg::CLOCK_MAX : sum[KW-1:0];
                n_last       = sel.idx;
                if (rr) begin
                    n_rr_started = 1'b1;
                end
                n_pid        = sel.pid;
                n_start      = start;
                n_end        = sum[KW] ? psched_pkg::CLOCK_MAX : sum[KW-1:0];
                n_pfin       = fin_now;
                n_all        = (r_undone == CW'(fin_now));
                n_out_valid  = 1'b1;
                n_fin        = 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_kind)
                            psched_pkg::KIND_LOAD: begin
                                if (r_count < CW'(psched_pkg::MAX_PROCS)) begin
                                    st_we    = 1'b1;
                                    rm_we    = 1'b1;
                                    n_done[r_count[IW-1:0]] = 1'b0;
                                    n_count  = r_count + 1'b1;
                                    n_undone = r_undone + 1'b1;
                                end
                            end
                            psched_pkg::KIND_STEP: begin
                                if (r_undone != '0) begin
                                    n_iss     = '0;
                                    n_min.vld = 1'b0;
                                    n_aft.vld = 1'b0;
                                    n_state   = rr ? S_LA : S_SCAN;
                                end
                            end
                            psched_pkg::KIND_CLEAR: begin
                                n_count      = '0;
                                n_undone     = '0;
                                n_done       = '0;
                                n_clock      = '0;
                                n_last       = '0;
                                n_rr_started = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LA: begin
                    n_state = S_LAW;
                end
                S_LAW: begin
                    n_la    = st_rdata.arrival;
                    n_state = S_SCAN;
                end
                S_SCAN: begin
                    if (r_iss < r_count) begin
                        n_iss  = r_iss + 1'b1;
                        n_dv   = 1'b1;
                        n_didx = r_iss[IW-1:0];
                    end else if (!r_dv) begin
                        n_state = S_IDLE;
                        n_fin   = 1'b1;
                    end
                    if (r_dv && !r_done[r_didx]) begin
                        if (!r_min.vld || (key < r_min.key)) begin
                            n_min = '{vld: 1'b1, key: key, idx: r_didx, pid: st_rdata.pid,
                                      arr: st_rdata.arrival, rem: rm_rdata};
                        end
                        if (after_ok && (!r_aft.vld || (st_rdata.arrival < r_aft.arr))) begin
                            n_aft = '{vld: 1'b1, key: st_rdata.arrival, idx: r_didx,
                                      pid: st_rdata.pid, arr: st_rdata.arrival,
                                      rem: rm_rdata};
                        end
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fin        <= 1'b0;
            r_mode       <= psched_pkg::MODE_FCFS;
            r_quantum    <= FW'(1);
            r_count      <= '0;
            r_undone     <= '0;
            r_clock      <= '0;
            r_last       <= '0;
            r_rr_started <= 1'b0;
            r_done       <= '0;
            r_iss        <= '0;
            r_dv         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fin        <= n_fin;
            r_mode       <= n_mode;
            r_quantum    <= n_quantum;
            r_count      <= n_count;
            r_undone     <= n_undone;
            r_clock      <= n_clock;
            r_last       <= n_last;
            r_rr_started <= n_rr_started;
            r_done       <= n_done;
            r_iss        <= n_iss;
            r_dv         <= n_dv;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx  <= n_didx;
        r_la    <= n_la;
        r_min   <= n_min;
        r_aft   <= n_aft;
        r_pid   <= n_pid;
        r_start <= n_start;
        r_end   <= n_end;
        r_pfin  <= n_pfin;
        r_all   <= n_all;
    end

    assign o_out_valid     = r_out_valid;
    assign o_slice_pid     = r_pid;
    assign o_slice_start   = r_start;
    assign o_slice_end     = r_end;
    assign o_proc_finished = r_pfin;
    assign o_all_done      = r_all;

endmodule

>>> rtl/psched_chk.sv
// ----------------------------------------------------------------------------
// psched_chk
// Port-level checks for the process scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module psched_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_slice_pid,
    input logic [23:0] o_slice_start,
    input logic [23:0] o_slice_end,
    input logic        o_proc_finished,
    input logic        o_all_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_slice_pid)
            && $stable(o_slice_start) && $stable(o_slice_end))
        else $error("result transaction dropped or changed while stalled");

    a_slice_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_slice_start <= o_slice_end)
        else $error("slice ends before it starts");

    a_all_done_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_all_done |-> o_proc_finished)
        else $error("last slice does not finish its process");

endmodule

bind process_scheduler_fcfs_sjf_prio_rr psched_chk u_psched_chk (.*);
